FILE: rtl/bcm_pkg.sv
// ----------------------------------------------------------------------------
// bcm_pkg
// Shared types and constants for the banked cartridge mapper.
// ----------------------------------------------------------------------------
package bcm_pkg;

	localparam int REGION_COUNT = 8;
	localparam int BLOCK_BYTES  = 8192;

	// Fixed register addresses in the mapper window
	localparam logic [15:0] ADDR_BANK_LO   = 16'h6000;
	localparam logic [15:0] ADDR_RB_FIRST  = 16'h7FF0;
	localparam logic [15:0] ADDR_BANK_HI   = 16'h7FF8;
	localparam logic [15:0] ADDR_CTRL      = 16'h7FF9;

	// Control byte bits that enable readback
	localparam int CTRL_RB_LO_BIT   = 2;
	localparam int CTRL_RB_CTRL_BIT = 3;
	localparam int CTRL_RB_HI_BIT   = 4;

	localparam logic [5:0] SRAM_BANK_TOP = 6'h10; // bank[8:3] of banks 0x80..0x87
	localparam logic [1:0] RAM_BANK_TOP  = 2'b11; // bank[8:7] of banks from 0x180
	localparam logic [3:0] SRAM_LIMIT_MAX = 4'd8;

	typedef enum logic [2:0] {
		KIND_NONE = 3'd0,
		KIND_REG  = 3'd1,
		KIND_ROM  = 3'd2,
		KIND_SRAM = 3'd3,
		KIND_RAM  = 3'd4
	} target_kind_t;

	typedef enum logic [1:0] {
		CFG_SRAM_LIMIT = 2'd0,
		CFG_SRAM_MASK  = 2'd1,
		CFG_RAM_PRES   = 2'd2,
		CFG_ROM_MASK   = 2'd3
	} cfg_idx_t;

	typedef logic [REGION_COUNT-1:0][8:0] bank_arr_t;

	typedef struct packed {
		logic [3:0] sram_bank_limit;
		logic [2:0] sram_block_mask;
		logic       ram_present;
		logic [8:0] rom_block_mask;
	} cfg_t;

	// Register file updates caused by one request
	typedef struct packed {
		logic       lo_we;
		logic [2:0] lo_idx;
		logic       hi_we;
		logic       ctrl_we;
		logic [7:0] data;
	} regs_upd_t;

	typedef struct packed {
		logic [7:0]   read_data;
		target_kind_t target_kind;
		logic [8:0]   target_block;
		logic [12:0]  target_offset;
		logic         memory_write;
	} result_t;

endpackage

FILE: rtl/banked_cartridge_mapper_unit.sv
// ----------------------------------------------------------------------------
// banked_cartridge_mapper_unit
// Bus access decoder for an eight-region banked cartridge mapper.
// ----------------------------------------------------------------------------
// Channel   Direction  Contents
// s_*       in         request: tuser operation, tdata address / write_data
// m_*       out        result: tuser target_kind, tdata read_data .. memory_write
// cfg_*     in         register write: index 0..3, data up to 9 bits
//
// One request per cycle while the result is not stalled; a request is taken into
// the input register, and its decode result is then loaded into the result
// register, which raises m_tvalid.
// Reset clears bank selects, control byte and configuration (ROM mask 511).
// A stalled result holds in the output register; the input register still
// takes a request while empty or while the result register is free or draining.
// ----------------------------------------------------------------------------
module banked_cartridge_mapper_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [15:0] address, [23:16] write_data
	input  logic [0:0]  s_tuser,   // [0] operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [7:0] read_data, [16:8] target_block,
	                               // [29:17] target_offset, [30] memory_write, [31] zero
	output logic [2:0]  m_tuser,   // [2:0] target_kind
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [8:0]  cfg_data
);

	logic               valid_s1;
	logic               op_s1;
	logic [15:0]        addr_s1;
	logic [7:0]         wdata_s1;
	logic               valid_q;
	bcm_pkg::result_t   res_q;
	bcm_pkg::result_t   res;
	bcm_pkg::regs_upd_t upd;
	bcm_pkg::bank_arr_t bank_sel;
	logic [7:0]         ctrl;
	bcm_pkg::cfg_t      cfg_q;
	logic               advance;
	logic               s_acc;

	assign advance  = valid_s1 && (!valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign s_acc    = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{sram_bank_limit: 4'd0, sram_block_mask: 3'd0,
				ram_present: 1'b0, rom_block_mask: 9'h1FF};
		end else if (cfg_we) begin
			case (bcm_pkg::cfg_idx_t'(cfg_index))
				bcm_pkg::CFG_SRAM_LIMIT: cfg_q.sram_bank_limit <= cfg_data[3:0];
				bcm_pkg::CFG_SRAM_MASK:  cfg_q.sram_block_mask <= cfg_data[2:0];
				bcm_pkg::CFG_RAM_PRES:   cfg_q.ram_present     <= cfg_data[0];
				bcm_pkg::CFG_ROM_MASK:   cfg_q.rom_block_mask  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			op_s1    <= s_tuser[0];
			addr_s1  <= s_tdata[15:0];
			wdata_s1 <= s_tdata[23:16];
		end
	end

	bcm_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.upd_en   (advance),
		.upd      (upd),
		.bank_sel (bank_sel),
		.ctrl     (ctrl)
	);

	bcm_decode u_decode (
		.operation  (op_s1),
		.address    (addr_s1),
		.write_data (wdata_s1),
		.bank_sel   (bank_sel),
		.ctrl       (ctrl),
		.cfg        (cfg_q),
		.res        (res),
		.upd        (upd)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tuser  = res_q.target_kind;
	assign m_tdata  = {1'b0, res_q.memory_write, res_q.target_offset,
		res_q.target_block, res_q.read_data};

	// A stored write always lands in SRAM or RAM
	a_mw_kind: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && res_q.memory_write |->
		(res_q.target_kind == bcm_pkg::KIND_SRAM) || (res_q.target_kind == bcm_pkg::KIND_RAM))
		else $error("memory write to non-writable target");

	// Readback data only accompanies a register target
	a_rd_reg: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && (res_q.read_data != 8'd0) |-> res_q.target_kind == bcm_pkg::KIND_REG)
		else $error("read data on non-register target");

	// Register and dropped targets carry no block or offset
	a_no_loc: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && ((res_q.target_kind == bcm_pkg::KIND_REG) ||
		(res_q.target_kind == bcm_pkg::KIND_NONE)) |->
		(res_q.target_block == 9'd0) && (res_q.target_offset == 13'd0))
		else $error("location on register or dropped target");

	// A held request is never lost
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("input register dropped a request");

	// Control write takes effect on the following cycle
	a_ctrl_wr: assert property (@(posedge clk) disable iff (!arst_n)
		advance && upd.ctrl_we |=> ctrl == $past(upd.data))
		else $error("control byte not loaded");

endmodule

FILE: rtl/bcm_regs.sv
// ----------------------------------------------------------------------------
// bcm_regs
// Bank select registers and control byte, loaded by mapper register writes.
// ----------------------------------------------------------------------------
module bcm_regs (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               upd_en,
	input  bcm_pkg::regs_upd_t upd,
	output bcm_pkg::bank_arr_t bank_sel,
	output logic [7:0]         ctrl
);

	bcm_pkg::bank_arr_t bank_q;
	logic [7:0]         ctrl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q <= '0;
			ctrl_q <= '0;
		end else if (upd_en) begin
			for (int i = 0; i < bcm_pkg::REGION_COUNT; i++) begin
				if (upd.lo_we && (upd.lo_idx == 3'(i))) begin
					bank_q[i][7:0] <= upd.data;
				end
				if (upd.hi_we) begin
					bank_q[i][8] <= upd.data[i];
				end
			end
			if (upd.ctrl_we) begin
				ctrl_q <= upd.data;
			end
		end
	end

	assign bank_sel = bank_q;
	assign ctrl     = ctrl_q;

endmodule

FILE: rtl/bcm_decode.sv
// ----------------------------------------------------------------------------
// bcm_decode
// Decodes one bus access against the bank selects and configuration.
// ----------------------------------------------------------------------------
module bcm_decode (
	input  logic               operation,
	input  logic [15:0]        address,
	input  logic [7:0]         write_data,
	input  bcm_pkg::bank_arr_t bank_sel,
	input  logic [7:0]         ctrl,
	input  bcm_pkg::cfg_t      cfg,
	output bcm_pkg::result_t   res,
	output bcm_pkg::regs_upd_t upd
);

	logic [2:0]             region;
	logic [8:0]             bank;
	logic [3:0]             lim;
	logic                   is_sram;
	logic                   is_ram;
	bcm_pkg::target_kind_t  mkind;
	logic [8:0]             mblock;
	logic                   wr_lo;
	logic                   wr_hi;
	logic                   wr_ctrl;
	logic                   wr_mem;
	logic                   rb_lo;
	logic                   rb_hi;
	logic                   rb_ctrl;
	logic [2:0]             lo_idx;
	logic [7:0]             hi_bits;

	assign region = address[15:13];
	assign bank   = bank_sel[region];

	// Clamp oversized SRAM limit to eight banks
	assign lim = (cfg.sram_bank_limit > bcm_pkg::SRAM_LIMIT_MAX) ?
		bcm_pkg::SRAM_LIMIT_MAX : cfg.sram_bank_limit;

	assign is_sram = (bank[8:3] == bcm_pkg::SRAM_BANK_TOP) && ({1'b0, bank[2:0]} < lim);
	assign is_ram  = cfg.ram_present && (bank[8:7] == bcm_pkg::RAM_BANK_TOP);

	always_comb begin
		if (is_sram) begin
			mkind  = bcm_pkg::KIND_SRAM;
			mblock = {6'd0, bank[2:0] & cfg.sram_block_mask};
		end else if (is_ram) begin
			mkind  = bcm_pkg::KIND_RAM;
			mblock = {2'd0, bank[6:0]};
		end else begin
			mkind  = bcm_pkg::KIND_ROM;
			mblock = bank & cfg.rom_block_mask;
		end
	end

	// Low bank window 0x6000..0x7FEF, bank high 0x7FF8, control 0x7FF9, memory 0x8000..0xBFFF
	assign wr_lo   = operation && (address[15:13] == bcm_pkg::ADDR_BANK_LO[15:13]) &&
		(address[15:4] != bcm_pkg::ADDR_RB_FIRST[15:4]);
	assign wr_hi   = operation && (address == bcm_pkg::ADDR_BANK_HI);
	assign wr_ctrl = operation && (address == bcm_pkg::ADDR_CTRL);
	assign wr_mem  = operation && (address[15:14] == 2'b10) &&
		((mkind == bcm_pkg::KIND_SRAM) || (mkind == bcm_pkg::KIND_RAM));

	assign rb_lo   = !operation && ctrl[bcm_pkg::CTRL_RB_LO_BIT] &&
		(address[15:3] == bcm_pkg::ADDR_RB_FIRST[15:3]);
	assign rb_hi   = !operation && ctrl[bcm_pkg::CTRL_RB_HI_BIT] &&
		(address == bcm_pkg::ADDR_BANK_HI);
	assign rb_ctrl = !operation && ctrl[bcm_pkg::CTRL_RB_CTRL_BIT] &&
		(address == bcm_pkg::ADDR_CTRL);

	// Regions 5 and 6 are swapped on the low bank write
	always_comb begin
		case (address[12:10])
			3'd5:    lo_idx = 3'd6;
			3'd6:    lo_idx = 3'd5;
			default: lo_idx = address[12:10];
		endcase
	end

	always_comb begin
		for (int i = 0; i < bcm_pkg::REGION_COUNT; i++) begin
			hi_bits[i] = bank_sel[i][8];
		end
	end

	always_comb begin
		res = '0;
		if (wr_lo || wr_hi || wr_ctrl) begin
			res.target_kind = bcm_pkg::KIND_REG;
		end else if (wr_mem) begin
			res.target_kind   = mkind;
			res.target_block  = mblock;
			res.target_offset = address[12:0];
			res.memory_write  = 1'b1;
		end else if (operation) begin
			res.target_kind = bcm_pkg::KIND_NONE;
		end else if (rb_lo) begin
			res.target_kind = bcm_pkg::KIND_REG;
			res.read_data   = bank_sel[address[2:0]][7:0];
		end else if (rb_hi) begin
			res.target_kind = bcm_pkg::KIND_REG;
			res.read_data   = hi_bits;
		end else if (rb_ctrl) begin
			res.target_kind = bcm_pkg::KIND_REG;
			res.read_data   = ctrl;
		end else begin
			res.target_kind   = mkind;
			res.target_block  = mblock;
			res.target_offset = address[12:0];
		end
	end

	assign upd.lo_we   = wr_lo;
	assign upd.lo_idx  = lo_idx;
	assign upd.hi_we   = wr_hi;
	assign upd.ctrl_we = wr_ctrl;
	assign upd.data    = write_data;

endmodule
